@@ design/krt_pkg.sv @@
// Shared types and codes for the keyed record table.
`default_nettype none

package krt_pkg;

	// Command codes carried on the input tuser
	typedef enum logic [2:0] {
		CMD_INSERT      = 3'd0,
		CMD_FIND_KEY    = 3'd1,
		CMD_FIND_NAME   = 3'd2,
		CMD_FIND_COURSE = 3'd3,
		CMD_DELETE      = 3'd4,
		CMD_UPDATE      = 3'd5
	} cmd_e;

	// Result status codes carried on the output tuser
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	// Width of a cell position; covers table depths up to 64
	localparam int POS_W = 6;

	// One stored record
	typedef struct packed {
		logic signed [31:0] key;
		logic [63:0]        name;
		logic [63:0]        course;
	} rec_t;

	// Per-cycle operation applied to the whole chain of cells
	typedef enum logic [1:0] {
		OP_HOLD,
		OP_ROTATE,
		OP_SHIFT_DN,
		OP_SHIFT_UP
	} chain_op_e;

	typedef struct packed {
		chain_op_e          op;
		logic [POS_W-1:0]   pos;
		logic               mod_en;
	} chain_ctl_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN,
		S_FINISH
	} state_e;

endpackage

`default_nettype wire

@@ design/krt_cell.sv @@
// One record cell of the chain: holds, or takes from a neighbour.
`default_nettype none

module krt_cell
	import krt_pkg::*;
#(
	parameter int IDX = 0
) (
	input  wire logic       clk,
	input  wire chain_ctl_t ctl,
	input  wire rec_t       prev_rec,
	input  wire rec_t       next_rec,
	output rec_t            rec
);

	localparam logic [POS_W-1:0] IDX_POS = POS_W'(IDX);

	rec_t rec_q;

	// Take the neighbour's record as the chain operation asks
	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_ROTATE:   rec_q <= next_rec;
			OP_SHIFT_DN: rec_q <= prev_rec;
			OP_SHIFT_UP: begin
				if (IDX_POS >= ctl.pos) begin
					rec_q <= next_rec;
				end
			end
			default: ;
		endcase
	end

	assign rec = rec_q;

endmodule

`default_nettype wire

@@ design/krt_ctrl.sv @@
// Command sequencer: accepts commands, steers the chain, builds results.
`default_nettype none

module krt_ctrl
	import krt_pkg::*;
#(
	parameter int TABLE_DEPTH = 16,
	parameter int NAME_BYTES  = 8,
	parameter int CNT_W       = 5
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// command side
	input  wire logic             s_valid,
	output logic                  s_ready,
	input  wire logic [2:0]       s_cmd,
	input  wire rec_t             s_rec,
	// chain side
	input  wire rec_t             head_rec,
	output chain_ctl_t            ctl,
	output rec_t                  new_rec,
	// result side
	output logic                  m_valid,
	input  wire logic             m_ready,
	output logic [1:0]            m_status,
	output rec_t                  m_rec,
	output logic                  m_last,
	output logic [CNT_W-1:0]      m_count
);

	localparam int          SW        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [63:0] TEXT_MASK = (NAME_BYTES >= 8) ? {64{1'b1}} :
		((64'd1 << (8 * NAME_BYTES)) - 64'd1);

	state_e            state_q, state_d;
	logic [2:0]        cmd_q;
	rec_t              new_rec_q;
	logic [SW-1:0]     step_q;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic              stage_v_q;
	rec_t              stage_q;
	logic [POS_W-1:0]  pos_q;
	logic              out_v_q;
	logic [1:0]        out_status_q;
	rec_t              out_rec_q;
	logic              out_last_q;
	logic [CNT_W-1:0]  out_cnt_q;

	logic              out_free, is_key_cmd, head_live, hit, scan_last, full;
	logic              step_adv;
	logic              emit, emit_last;
	logic [1:0]        emit_status;
	rec_t              emit_rec;

	// Head compare and scan bookkeeping
	always_comb begin
		out_free   = !out_v_q || m_ready;
		is_key_cmd = (cmd_q == CMD_FIND_KEY) || (cmd_q == CMD_DELETE) ||
			(cmd_q == CMD_UPDATE);
		head_live  = CNT_W'(step_q) < cnt_q;
		scan_last  = step_q == SW'(TABLE_DEPTH - 1);
		full       = cnt_q == CNT_W'(TABLE_DEPTH);
		if (is_key_cmd) begin
			hit = head_live && !stage_v_q && (head_rec.key == new_rec_q.key);
		end else if (cmd_q == CMD_FIND_NAME) begin
			hit = head_live && (head_rec.name == new_rec_q.name);
		end else begin
			hit = head_live && (head_rec.course == new_rec_q.course);
		end
		step_adv = (state_q == S_SCAN) && out_free;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_valid) state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				case (cmd_q)
					CMD_FIND_KEY, CMD_FIND_NAME, CMD_FIND_COURSE,
					CMD_DELETE, CMD_UPDATE: state_d = S_SCAN;
					default: begin
						if (out_free) state_d = S_IDLE;
					end
				endcase
			end
			S_SCAN: begin
				if (out_free && scan_last) state_d = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs: chain operation, result to emit, next count
	always_comb begin
		s_ready     = state_q == S_IDLE;
		ctl.op      = OP_HOLD;
		ctl.pos     = pos_q;
		ctl.mod_en  = 1'b0;
		emit        = 1'b0;
		emit_status = ST_OK;
		emit_rec    = '0;
		emit_last   = 1'b1;
		cnt_d       = cnt_q;
		case (state_q)
			S_DISPATCH: begin
				case (cmd_q)
					CMD_INSERT: begin
						emit = out_free;
						if (full) begin
							emit_status = ST_FULL;
						end else begin
							emit_rec = new_rec_q;
							if (out_free) begin
								ctl.op = OP_SHIFT_DN;
								cnt_d  = cnt_q + 1'b1;
							end
						end
					end
					CMD_FIND_KEY, CMD_FIND_NAME, CMD_FIND_COURSE,
					CMD_DELETE, CMD_UPDATE: ;
					default: begin
						emit        = out_free;
						emit_status = ST_NOT_FOUND;
					end
				endcase
			end
			S_SCAN: begin
				if (out_free) begin
					ctl.op     = OP_ROTATE;
					ctl.mod_en = hit && (cmd_q == CMD_UPDATE);
					// a new text match pushes the held one out
					if (hit && !is_key_cmd && stage_v_q) begin
						emit      = 1'b1;
						emit_rec  = stage_q;
						emit_last = 1'b0;
					end
				end
			end
			S_FINISH: begin
				if (out_free) begin
					emit = 1'b1;
					if (stage_v_q) begin
						emit_rec = stage_q;
						if (cmd_q == CMD_DELETE) begin
							ctl.op = OP_SHIFT_UP;
							cnt_d  = cnt_q - 1'b1;
						end
					end else begin
						emit_status = ST_NOT_FOUND;
					end
				end
			end
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			out_v_q   <= 1'b0;
			stage_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (m_ready) begin
				out_v_q <= 1'b0;
			end
			if (state_q == S_DISPATCH) begin
				stage_v_q <= 1'b0;
			end else if (step_adv && hit) begin
				stage_v_q <= 1'b1;
			end
		end
	end

	// Command, scan and result payload
	always_ff @(posedge clk) begin
		if (s_ready && s_valid) begin
			cmd_q            <= s_cmd;
			new_rec_q.key    <= s_rec.key;
			new_rec_q.name   <= s_rec.name & TEXT_MASK;
			new_rec_q.course <= s_rec.course & TEXT_MASK;
		end
		if (state_q == S_DISPATCH) begin
			step_q <= '0;
		end else if (step_adv) begin
			step_q <= step_q + 1'b1;
		end
		if (step_adv && hit) begin
			pos_q <= POS_W'(step_q);
			if (cmd_q == CMD_UPDATE) begin
				stage_q <= '{key: head_rec.key, name: new_rec_q.name,
					course: new_rec_q.course};
			end else begin
				stage_q <= head_rec;
			end
		end
		if (emit) begin
			out_status_q <= emit_status;
			out_rec_q    <= emit_rec;
			out_last_q   <= emit_last;
			out_cnt_q    <= cnt_d;
		end
	end

	assign new_rec  = new_rec_q;
	assign m_valid  = out_v_q;
	assign m_status = out_status_q;
	assign m_rec    = out_rec_q;
	assign m_last   = out_last_q;
	assign m_count  = out_cnt_q;

endmodule

`default_nettype wire

@@ design/keyed_record_table.sv @@
// Top level of the keyed record table: sequencer and chain of record cells.
//
// Records live in a chain of TABLE_DEPTH cells, newest in cell 0. Insert moves
// the chain down one cell and answers from the dispatch state, as do an
// undefined command and a full table. Key lookup, delete, update and the name
// and course searches rotate the chain one cell per cycle, while the result
// side does not stall, past a comparator on cell 0 and give their final result
// once the chain has come full circle. For delete, the closing move-up of older
// records happens with the final result. A new command is accepted once the
// previous one has produced its last result; that result may still wait in
// the output register. Reset empties the table at once through its record
// count; there is no clearing pass.
`default_nettype none

module keyed_record_table
	import krt_pkg::*;
#(
	parameter int TABLE_DEPTH = 16,
	parameter int NAME_BYTES  = 8,
	localparam int CNT_W      = $clog2(TABLE_DEPTH + 1),
	localparam int M_TDATA_W  = ((160 + CNT_W + 7) / 8) * 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	// record_key [31:0], name_text [95:32], course_text [159:96]
	input  wire logic [159:0]         s_axis_tdata,
	// command [2:0]
	input  wire logic [2:0]           s_axis_tuser,
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	// found_key [31:0], found_name [95:32], found_course [159:96],
	// entries_in_use [159+CNT_W:160], zero fill above
	output logic [M_TDATA_W-1:0]      m_axis_tdata,
	// status [1:0]
	output logic [1:0]                m_axis_tuser,
	output logic                      m_axis_tlast
);

	rec_t             s_rec;
	rec_t             new_rec;
	rec_t             rot_in;
	rec_t             m_rec;
	rec_t             cell_rec [TABLE_DEPTH];
	chain_ctl_t       ctl;
	logic [CNT_W-1:0] m_count;

	// Unpack the input transfer
	assign s_rec = '{key: s_axis_tdata[31:0], name: s_axis_tdata[95:32],
		course: s_axis_tdata[159:96]};

	krt_ctrl #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.NAME_BYTES  (NAME_BYTES),
		.CNT_W       (CNT_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_valid  (s_axis_tvalid),
		.s_ready  (s_axis_tready),
		.s_cmd    (s_axis_tuser),
		.s_rec    (s_rec),
		.head_rec (cell_rec[0]),
		.ctl      (ctl),
		.new_rec  (new_rec),
		.m_valid  (m_axis_tvalid),
		.m_ready  (m_axis_tready),
		.m_status (m_axis_tuser),
		.m_rec    (m_rec),
		.m_last   (m_axis_tlast),
		.m_count  (m_count)
	);

	// Head record wraps to the tail, with new text on an update hit
	always_comb begin
		rot_in = cell_rec[0];
		if (ctl.mod_en) begin
			rot_in.name   = new_rec.name;
			rot_in.course = new_rec.course;
		end
	end

	// Chain of record cells
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		rec_t prev_rec, next_rec;
		if (i == 0) begin : g_head
			assign prev_rec = new_rec;
		end else begin : g_body
			assign prev_rec = cell_rec[i-1];
		end
		if (i == TABLE_DEPTH - 1) begin : g_tail
			assign next_rec = rot_in;
		end else begin : g_mid
			assign next_rec = cell_rec[i+1];
		end
		krt_cell #(
			.IDX (i)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.prev_rec (prev_rec),
			.next_rec (next_rec),
			.rec      (cell_rec[i])
		);
	end

	// Pack the output transfer
	assign m_axis_tdata = M_TDATA_W'({m_count, m_rec.course, m_rec.name, m_rec.key});

`ifndef SYNTHESIS
	// Record count in a result never exceeds the table depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[159+CNT_W:160] <= CNT_W'(TABLE_DEPTH))
		else $error("entries_in_use above table depth");

	// Table full is reported only with every entry taken
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == ST_FULL) |->
			m_axis_tdata[159+CNT_W:160] == CNT_W'(TABLE_DEPTH))
		else $error("table_full with free entries");

	// A miss or a full table gives one zeroed, final result
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser != ST_OK) |->
			(m_axis_tlast && m_axis_tdata[159:0] == 160'd0))
		else $error("non-ok result with record data or not last");
`endif

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking bench for the keyed record table: directed and random commands.
`timescale 1ns / 1ps

module testbench;
	import krt_pkg::*;

	localparam int TABLE_DEPTH = 16;
	localparam int NAME_BYTES  = 8;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int M_TDATA_W   = ((160 + CNT_W + 7) / 8) * 8;
	localparam logic [63:0] TEXT_MASK =
		(NAME_BYTES >= 8) ? {64{1'b1}} : ((64'd1 << (8 * NAME_BYTES)) - 64'd1);

	// Command codes the block does not define; both must answer not_found
	localparam logic [2:0] CMD_SPARE_LO = 3'd6;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;

	typedef enum int {PHASE_GROW, PHASE_SHRINK, PHASE_MIXED} phase_e;

	typedef struct {
		logic [1:0]         status;
		logic signed [31:0] key;
		logic [63:0]        name;
		logic [63:0]        course;
		logic               last;
		logic [CNT_W-1:0]   count;
	} record_result_t;

	// Table contents mirrored newest first, and the answers still owed
	class record_table_model;
		logic signed [31:0] keys [TABLE_DEPTH];
		logic [63:0]        names [TABLE_DEPTH];
		logic [63:0]        courses [TABLE_DEPTH];
		int                 used;
		record_result_t     awaited_results [$];
		int failures, results_seen, commands_seen, full_answers, multi_searches;

		function new();
			used = 0;
			failures = 0;
			results_seen = 0;
			commands_seen = 0;
			full_answers = 0;
			multi_searches = 0;
		endfunction

		function void owe(logic [1:0] status, logic signed [31:0] key, logic [63:0] nm,
				logic [63:0] cr, logic last);
			record_result_t r;
			r.status = status;
			r.key    = key;
			r.name   = nm;
			r.course = cr;
			r.last   = last;
			r.count  = CNT_W'(used);
			awaited_results.push_back(r);
		endfunction

		// Work out the answers to one accepted command and update the mirror
		function void apply_command(logic [2:0] cmd, logic signed [31:0] key,
				logic [63:0] nm_in, logic [63:0] cr_in);
			logic [63:0]        nm, cr;
			logic signed [31:0] hit_key;
			logic [63:0]        hit_name, hit_course;
			int                 pos, hits;
			nm = nm_in & TEXT_MASK;
			cr = cr_in & TEXT_MASK;
			commands_seen++;
			case (cmd)
				CMD_INSERT: begin
					if (used >= TABLE_DEPTH) begin
						full_answers++;
						owe(ST_FULL, '0, '0, '0, 1'b1);
					end else begin
						for (int i = used; i > 0; i--) begin
							keys[i]    = keys[i-1];
							names[i]   = names[i-1];
							courses[i] = courses[i-1];
						end
						keys[0]    = key;
						names[0]   = nm;
						courses[0] = cr;
						used++;
						owe(ST_OK, key, nm, cr, 1'b1);
					end
				end
				CMD_FIND_KEY, CMD_DELETE, CMD_UPDATE: begin
					pos = -1;
					for (int i = 0; i < used; i++)
						if (pos < 0 && keys[i] == key)
							pos = i;
					if (pos < 0) begin
						owe(ST_NOT_FOUND, '0, '0, '0, 1'b1);
					end else begin
						if (cmd == CMD_UPDATE) begin
							names[pos]   = nm;
							courses[pos] = cr;
						end
						hit_key    = keys[pos];
						hit_name   = names[pos];
						hit_course = courses[pos];
						// close the gap left by a removed record
						if (cmd == CMD_DELETE) begin
							for (int i = pos; i + 1 < used; i++) begin
								keys[i]    = keys[i+1];
								names[i]   = names[i+1];
								courses[i] = courses[i+1];
							end
							used--;
						end
						owe(ST_OK, hit_key, hit_name, hit_course, 1'b1);
					end
				end
				CMD_FIND_NAME, CMD_FIND_COURSE: begin
					hits = 0;
					for (int i = 0; i < used; i++)
						if ((cmd == CMD_FIND_NAME) ? (names[i] == nm) : (courses[i] == cr)) begin
							owe(ST_OK, keys[i], names[i], courses[i], 1'b0);
							hits++;
						end
					if (hits == 0)
						owe(ST_NOT_FOUND, '0, '0, '0, 1'b1);
					else
						awaited_results[awaited_results.size()-1].last = 1'b1;
					if (hits > 1)
						multi_searches++;
				end
				default: begin
					owe(ST_NOT_FOUND, '0, '0, '0, 1'b1);
				end
			endcase
		endfunction

		// Compare one output transfer with the oldest answer owed
		function void check_result(logic [1:0] status, logic signed [31:0] key,
				logic [63:0] nm, logic [63:0] cr, logic last, logic [CNT_W-1:0] count);
			record_result_t want;
			results_seen++;
			if (awaited_results.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("%0t: unexpected result: status %0d key %0d name %h course %h",
						$realtime, status, key, nm, cr);
				return;
			end
			want = awaited_results.pop_front();
			if (want.status !== status || want.key !== key || want.name !== nm ||
					want.course !== cr || want.last !== last || want.count !== count) begin
				failures++;
				if (failures <= 10) begin
					$display("%0t: mismatch, expected status %0d key %0d name %h course %h",
						$realtime, want.status, want.key, want.name, want.course);
					$display("    last %b count %0d; got status %0d key %0d name %h course %h",
						want.last, want.count, status, key, nm, cr);
					$display("    last %b count %0d", last, count);
				end
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [159:0]         s_axis_tdata = '0;
	logic [2:0]           s_axis_tuser = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic [1:0]           m_axis_tuser;
	logic                 m_axis_tlast;

	record_table_model table_model;
	phase_e            phase = PHASE_GROW;
	bit                steady = 1'b0;

	keyed_record_table #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.NAME_BYTES(NAME_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always #5 clk = ~clk;

	// Mostly keys that are likely stored, sometimes any value
	function automatic logic signed [31:0] pick_key();
		if ($urandom_range(0, 99) >= 85)
			return $urandom();
		case ($urandom_range(0, 7))
			0: return 32'sh8000_0000;
			1: return 32'sh7FFF_FFFF;
			2: return 32'sd0;
			3: return -32'sd1;
			4: return 32'sd1;
			5: return 32'sh5A5A_5A5A;
			6: return 32'sd7;
			default: return 32'sd1000;
		endcase
	endfunction

	// Small pool of texts so that searches find several records
	function automatic logic [63:0] pick_text(bit for_course);
		if ($urandom_range(0, 99) >= 80)
			return {$urandom(), $urandom()};
		case ($urandom_range(0, 3))
			0: return 64'd0;
			1: return {64{1'b1}};
			2: return for_course ? 64'("MATH") : 64'("ALICE");
			default: return for_course ? 64'("PHYS") : 64'("BOB");
		endcase
	endfunction

	// Bias the command mix by phase: fill the table, drain it, or mix
	function automatic logic [2:0] pick_command(phase_e ph);
		int r, ins, del;
		r   = $urandom_range(0, 99);
		ins = (ph == PHASE_GROW) ? 70 : (ph == PHASE_SHRINK) ? 15 : 35;
		del = (ph == PHASE_GROW) ? 5 : (ph == PHASE_SHRINK) ? 50 : 20;
		if (r < ins)
			return CMD_INSERT;
		if (r < ins + del)
			return CMD_DELETE;
		case (r % 9)
			0, 1: return CMD_FIND_KEY;
			2, 3: return CMD_FIND_NAME;
			4, 5: return CMD_FIND_COURSE;
			6, 7: return CMD_UPDATE;
			default: return $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
		endcase
	endfunction

	// Offer one command after a random gap and hold it until the transfer
	task automatic send_command(logic [2:0] cmd, logic signed [31:0] key,
			logic [63:0] nm, logic [63:0] cr);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {cr, nm, key};
		s_axis_tuser  <= cmd;
		do @(posedge clk); while (!s_axis_tready);
		table_model.apply_command(cmd, key, nm, cr);
	endtask

	// Result side: stall at random, check every transfer
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			table_model.check_result(m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[95:32],
				m_axis_tdata[159:96], m_axis_tlast, m_axis_tdata[160 +: CNT_W]);
		end
	end

	// Stimulus
	initial begin
		table_model = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// lookups, edits and a spare code on an empty table
		send_command(CMD_FIND_KEY, 32'sd0, '0, '0);
		send_command(CMD_FIND_NAME, 32'sd0, '0, '0);
		send_command(CMD_FIND_COURSE, 32'sd0, '0, '0);
		send_command(CMD_DELETE, 32'sd0, '0, '0);
		send_command(CMD_UPDATE, 32'sd0, '0, '0);
		send_command(CMD_SPARE_LO, 32'sd0, '0, '0);
		// extreme keys and texts, a duplicate key
		send_command(CMD_INSERT, 32'sh8000_0000, {64{1'b1}}, 64'd0);
		send_command(CMD_INSERT, 32'sh7FFF_FFFF, 64'd0, {64{1'b1}});
		send_command(CMD_INSERT, 32'sd0, 64'("ALICE"), 64'("MATH"));
		send_command(CMD_INSERT, -32'sd1, 64'("ALICE"), {64{1'b1}});
		send_command(CMD_INSERT, 32'sd0, 64'("BOB"), 64'("MATH"));
		// first match and multi-match searches
		send_command(CMD_FIND_KEY, 32'sd0, '0, '0);
		send_command(CMD_FIND_NAME, 32'sd0, 64'("ALICE"), '0);
		send_command(CMD_FIND_COURSE, 32'sd0, '0, {64{1'b1}});
		send_command(CMD_FIND_COURSE, 32'sd0, '0, 64'("MATH"));
		send_command(CMD_FIND_NAME, 32'sd0, {64{1'b1}}, '0);
		send_command(CMD_UPDATE, 32'sd0, 64'("CAROL"), 64'("ART"));
		send_command(CMD_FIND_KEY, 32'sh7FFF_FFFF, '0, '0);
		// delete the oldest record, then the newest of two equal keys
		send_command(CMD_DELETE, 32'sh8000_0000, '0, '0);
		send_command(CMD_DELETE, 32'sd0, '0, '0);
		send_command(CMD_FIND_KEY, 32'sd0, '0, '0);
		send_command(CMD_FIND_NAME, 32'sd0, 64'("NOBODY"), '0);
		send_command(CMD_SPARE_HI, -32'sd1, {64{1'b1}}, {64{1'b1}});

		// random rounds: two filling rounds reach a full table, then a drain
		for (int round = 0; round < 9; round++) begin
			phase  = (round < 2) ? PHASE_GROW : (round == 2) ? PHASE_SHRINK :
				phase_e'($urandom_range(0, 2));
			steady = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < 38; n++)
				send_command(pick_command(phase), pick_key(), pick_text(1'b0), pick_text(1'b1));
		end
		s_axis_tvalid <= 1'b0;
		steady = 1'b0;

		// drain outstanding answers, then allow stray results to show up
		while (table_model.awaited_results.size() != 0) @(posedge clk);
		repeat (TABLE_DEPTH + 8) @(posedge clk);

		$display("summary: %0d commands, %0d results checked, %0d mismatches",
			table_model.commands_seen, table_model.results_seen, table_model.failures);
		$display("summary: %0d answers with the table full, %0d searches with several matches",
			table_model.full_answers, table_model.multi_searches);
		if (table_model.failures == 0 && table_model.awaited_results.size() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("testbench: timeout");
		$display("testbench: done, errors");
		$finish;
	end

endmodule
